/* rtl/pifct_pkg.sv */
// Shared types, constants and the crossing table for the point-in-face test.
// Used by pifct_ctrl, pifct_datapath and point_in_face_crossing_test_unit.
`default_nettype none

package pifct_pkg;

   // field widths
   localparam int COORD_W  = 32;
   localparam int TOL_W    = 16;
   localparam int VERT_W   = 10;
   localparam int LOOP_W   = 4;
   localparam int REGION_W = 4;
   localparam int RES_W    = 2;
   // one extra bit for a difference, one more for point +/- tolerance - vertex
   localparam int MUL_W    = COORD_W + 2;
   localparam int PROD_W   = 2 * MUL_W;

   localparam logic [VERT_W-1:0] VERT_MAX  = {VERT_W{1'b1}};
   localparam logic [LOOP_W-1:0] LOOP_MAX  = {LOOP_W{1'b1}};
   localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(16);

   typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_type;

   typedef enum logic [1:0] {EC_NONE, EC_CROSS, EC_BOUND, EC_EXACT} edge_code_type;

   typedef enum logic [RES_W-1:0] {RES_OUTSIDE, RES_INSIDE, RES_BOUNDARY} res_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_OPEN, ST_TAB, ST_MUL_P, ST_MUL_Q1, ST_CMP1, ST_CMP2,
      ST_ADVANCE, ST_END_LOOP, ST_OUT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic open_loop;
      logic advance;
      logic sel_close;
      logic tab_apply;
      logic mul_p;
      logic mul_q1;
      logic cmp1;
      logic cmp_apply;
      logic end_loop;
      logic emit;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic first;
      logic closing;
      logic last_face;
      logic exact_needed;
      logic rsp_free;
   } stat_type;

   // crossing table, row is end region, column is start region
   localparam edge_code_type CROSS_TAB [0:8][0:8] = '{
      '{EC_NONE,  EC_NONE,  EC_CROSS, EC_NONE,  EC_BOUND, EC_CROSS, EC_NONE,  EC_NONE,  EC_EXACT},
      '{EC_NONE,  EC_NONE,  EC_CROSS, EC_NONE,  EC_BOUND, EC_CROSS, EC_NONE,  EC_BOUND, EC_CROSS},
      '{EC_CROSS, EC_CROSS, EC_NONE,  EC_CROSS, EC_BOUND, EC_NONE,  EC_EXACT, EC_NONE,  EC_NONE },
      '{EC_NONE,  EC_NONE,  EC_CROSS, EC_NONE,  EC_BOUND, EC_BOUND, EC_NONE,  EC_NONE,  EC_NONE },
      '{EC_BOUND, EC_BOUND, EC_BOUND, EC_BOUND, EC_BOUND, EC_BOUND, EC_BOUND, EC_BOUND, EC_BOUND},
      '{EC_CROSS, EC_CROSS, EC_NONE,  EC_BOUND, EC_BOUND, EC_NONE,  EC_NONE,  EC_NONE,  EC_NONE },
      '{EC_NONE,  EC_NONE,  EC_EXACT, EC_NONE,  EC_BOUND, EC_NONE,  EC_NONE,  EC_NONE,  EC_NONE },
      '{EC_NONE,  EC_BOUND, EC_NONE,  EC_NONE,  EC_BOUND, EC_NONE,  EC_NONE,  EC_NONE,  EC_NONE },
      '{EC_EXACT, EC_CROSS, EC_NONE,  EC_NONE,  EC_BOUND, EC_NONE,  EC_NONE,  EC_NONE,  EC_NONE }
   };

endpackage

`default_nettype wire

/* rtl/pifct_ctrl.sv */
// Sequencer for the point-in-face test: steps each vertex word through its
// edges, the exact compare and the loop close. Depends on pifct_pkg.
`default_nettype none

module pifct_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_op,
   output logic                   req_stall,
   input  wire pifct_pkg::stat_type stat,
   output pifct_pkg::cmd_type     cmd
);
   import pifct_pkg::*;

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;   // set while working on the closing edge
   state_type edge_done;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      cmd           = '0;
      cmd.sel_close = phase_ff;
      req_stall     = 1'b1;
      edge_done     = phase_ff ? ST_END_LOOP : ST_ADVANCE;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_op) state_in = ST_OPEN;
            end
         end
         ST_OPEN: begin
            if (stat.first) begin
               cmd.open_loop = 1'b1;
               if (stat.closing) begin
                  phase_in = 1'b1;
                  state_in = ST_TAB;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               phase_in = 1'b0;
               state_in = ST_TAB;
            end
         end
         ST_TAB: begin
            cmd.tab_apply = 1'b1;
            state_in      = stat.exact_needed ? ST_MUL_P : edge_done;
         end
         ST_MUL_P: begin
            cmd.mul_p = 1'b1;
            state_in  = ST_MUL_Q1;
         end
         ST_MUL_Q1: begin
            cmd.mul_q1 = 1'b1;
            state_in   = ST_CMP1;
         end
         ST_CMP1: begin
            cmd.cmp1 = 1'b1;
            state_in = ST_CMP2;
         end
         ST_CMP2: begin
            cmd.cmp_apply = 1'b1;
            state_in      = edge_done;
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            if (stat.closing) begin
               phase_in = 1'b1;
               state_in = ST_TAB;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_END_LOOP: begin
            cmd.end_loop = 1'b1;
            state_in     = stat.last_face ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/pifct_datapath.sv */
// Datapath for the point-in-face test: query and vertex registers, region
// classify, crossing table, shared multiplier, loop verdict and result register.
// Depends on pifct_pkg.
`default_nettype none

module pifct_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_op,
   input  wire logic signed [pifct_pkg::COORD_W-1:0] req_coord_x,
   input  wire logic signed [pifct_pkg::COORD_W-1:0] req_coord_y,
   input  wire logic signed [pifct_pkg::COORD_W-1:0] req_coord_z,
   input  wire logic signed [pifct_pkg::COORD_W-1:0] req_normal_x,
   input  wire logic signed [pifct_pkg::COORD_W-1:0] req_normal_y,
   input  wire logic signed [pifct_pkg::COORD_W-1:0] req_normal_z,
   input  wire logic                            req_first_of_loop,
   input  wire logic                            req_last_of_loop,
   input  wire logic                            req_last_of_face,
   input  wire logic                            csr_we,
   input  wire logic [pifct_pkg::TOL_W-1:0]     csr_wdata,
   input  wire pifct_pkg::cmd_type              cmd,
   output pifct_pkg::stat_type                  stat,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [pifct_pkg::RES_W-1:0]          rsp_result_code,
   output logic [pifct_pkg::LOOP_W-1:0]         rsp_decided_loop,
   output logic [pifct_pkg::VERT_W-1:0]         rsp_decided_edge
);
   import pifct_pkg::*;

   // configuration and query
   logic [TOL_W-1:0]          tol_ff;
   axis_type                  axis_ff, axis_in;
   logic signed [COORD_W-1:0] qu_ff, qu_in, qv_ff, qv_in;
   // vertex registers
   logic signed [COORD_W-1:0] cur_u_ff, cur_u_in, cur_v_ff, cur_v_in;
   logic [REGION_W-1:0]       cur_r_ff, cur_r_in;
   logic signed [COORD_W-1:0] prev_u_ff, prev_u_in, prev_v_ff, prev_v_in;
   logic [REGION_W-1:0]       prev_r_ff, prev_r_in;
   logic signed [COORD_W-1:0] first_u_ff, first_u_in, first_v_ff, first_v_in;
   logic [REGION_W-1:0]       first_r_ff, first_r_in;
   logic first_ff, first_in, close_ff, close_in, lface_ff, lface_in;
   // face progress
   logic parity_ff, parity_in, loop_fin_ff, loop_fin_in, face_fin_ff, face_fin_in;
   logic outer_done_ff, outer_done_in;
   res_type                verdict_ff, verdict_in;
   logic [VERT_W-1:0]      vcnt_ff, vcnt_in, edge_mark_ff, edge_mark_in;
   logic [LOOP_W-1:0]      lcnt_ff, lcnt_in, loop_mark_ff, loop_mark_in;
   // exact compare
   logic signed [PROD_W-1:0] p_ff, p_in, q_ff, q_in;
   logic c1pos_ff, c1pos_in;
   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   res_type                rsp_code_ff, rsp_code_in;
   logic [LOOP_W-1:0]      rsp_loop_ff, rsp_loop_in;
   logic [VERT_W-1:0]      rsp_edge_ff, rsp_edge_in;

   // combinational helpers
   logic [COORD_W-1:0]        mag_x, mag_y, mag_z;
   axis_type                  new_axis;
   logic signed [COORD_W-1:0] in_u, in_v;
   logic signed [MUL_W-1:0]   tol_s, hi_u, lo_u, hi_v, lo_v;
   logic [REGION_W-1:0]       in_r;
   logic signed [COORD_W-1:0] u0, v0, u1, v1;
   logic [REGION_W-1:0]       r0, r1;
   edge_code_type             code;
   logic                      skip;
   logic signed [MUL_W-1:0]   d, mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic                      d_neg, p_gt_q, p_lt_q;
   res_type                   loop_res;

   // normal magnitudes and dropped axis
   always_comb begin
      mag_x = req_normal_x[COORD_W-1] ? -req_normal_x : req_normal_x;
      mag_y = req_normal_y[COORD_W-1] ? -req_normal_y : req_normal_y;
      mag_z = req_normal_z[COORD_W-1] ? -req_normal_z : req_normal_z;
      if (mag_x >= mag_y && mag_x >= mag_z) new_axis = AXIS_X;
      else if (mag_y >= mag_z)              new_axis = AXIS_Y;
      else                                  new_axis = AXIS_Z;
   end

   // projection of the incoming word, axis taken from the new or stored query
   always_comb begin
      axis_type a;
      a    = req_op ? axis_ff : new_axis;
      in_u = (a == AXIS_X) ? req_coord_y : req_coord_x;
      in_v = (a == AXIS_Z) ? req_coord_y : req_coord_z;
   end

   // region of the incoming vertex around the tolerance box
   always_comb begin
      logic [REGION_W-1:0] ru, rv;
      tol_s = MUL_W'(tol_ff);
      hi_u  = MUL_W'(qu_ff) + tol_s;
      lo_u  = MUL_W'(qu_ff) - tol_s;
      hi_v  = MUL_W'(qv_ff) + tol_s;
      lo_v  = MUL_W'(qv_ff) - tol_s;
      if (MUL_W'(in_u) > hi_u)      ru = REGION_W'(0);
      else if (MUL_W'(in_u) < lo_u) ru = REGION_W'(6);
      else                          ru = REGION_W'(3);
      if (MUL_W'(in_v) > hi_v)      rv = REGION_W'(0);
      else if (MUL_W'(in_v) < lo_v) rv = REGION_W'(2);
      else                          rv = REGION_W'(1);
      in_r = ru + rv;
   end

   // edge endpoints: previous to current, or current back to first
   always_comb begin
      if (cmd.sel_close) begin
         u0 = cur_u_ff;   v0 = cur_v_ff;   r0 = cur_r_ff;
         u1 = first_u_ff; v1 = first_v_ff; r1 = first_r_ff;
      end else begin
         u0 = prev_u_ff;  v0 = prev_v_ff;  r0 = prev_r_ff;
         u1 = cur_u_ff;   v1 = cur_v_ff;   r1 = cur_r_ff;
      end
      code = CROSS_TAB[r1][r0];
      skip = loop_fin_ff | face_fin_ff;
      d    = MUL_W'(v0) - MUL_W'(v1);
      d_neg = d[MUL_W-1];
   end

   // shared multiplier for the three products of the exact compare
   always_comb begin
      mul_a = MUL_W'(u0) - MUL_W'(u1);
      mul_b = MUL_W'(qv_ff) - MUL_W'(v1);
      if (cmd.mul_q1) begin
         mul_a = hi_u - MUL_W'(u1);
         mul_b = d;
      end else if (cmd.cmp1) begin
         mul_a = lo_u - MUL_W'(u1);
         mul_b = d;
      end
      prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
      p_gt_q = p_ff > q_ff;
      p_lt_q = p_ff < q_ff;
   end

   // verdict of the loop just closed
   always_comb begin
      if (loop_fin_ff)    loop_res = RES_BOUNDARY;
      else if (parity_ff) loop_res = RES_INSIDE;
      else                loop_res = RES_OUTSIDE;
   end

   // next state of all registers
   always_comb begin
      axis_in = axis_ff;   qu_in = qu_ff;   qv_in = qv_ff;
      cur_u_in = cur_u_ff; cur_v_in = cur_v_ff; cur_r_in = cur_r_ff;
      prev_u_in = prev_u_ff; prev_v_in = prev_v_ff; prev_r_in = prev_r_ff;
      first_u_in = first_u_ff; first_v_in = first_v_ff; first_r_in = first_r_ff;
      first_in = first_ff; close_in = close_ff; lface_in = lface_ff;
      parity_in = parity_ff; loop_fin_in = loop_fin_ff; face_fin_in = face_fin_ff;
      outer_done_in = outer_done_ff; verdict_in = verdict_ff;
      vcnt_in = vcnt_ff; lcnt_in = lcnt_ff;
      edge_mark_in = edge_mark_ff; loop_mark_in = loop_mark_ff;
      p_in = p_ff; q_in = q_ff; c1pos_in = c1pos_ff;
      rsp_code_in = rsp_code_ff; rsp_loop_in = rsp_loop_ff; rsp_edge_in = rsp_edge_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      // take in a word
      if (cmd.capture) begin
         cur_u_in = in_u;
         cur_v_in = in_v;
         cur_r_in = in_r;
         first_in = req_first_of_loop;
         close_in = req_last_of_loop | req_last_of_face;
         lface_in = req_last_of_face;
         if (!req_op) begin
            axis_in = new_axis;
            qu_in   = in_u;
            qv_in   = in_v;
            parity_in = 1'b0; loop_fin_in = 1'b0; face_fin_in = 1'b0;
            verdict_in = RES_OUTSIDE; vcnt_in = '0; lcnt_in = '0;
            edge_mark_in = '0; loop_mark_in = '0; outer_done_in = 1'b0;
         end
      end

      // first vertex of a loop
      if (cmd.open_loop) begin
         vcnt_in = '0; parity_in = 1'b0; loop_fin_in = 1'b0;
         first_u_in = cur_u_ff; first_v_in = cur_v_ff; first_r_in = cur_r_ff;
         prev_u_in  = cur_u_ff; prev_v_in  = cur_v_ff; prev_r_in  = cur_r_ff;
      end

      // step past an ordinary edge
      if (cmd.advance) begin
         if (vcnt_ff != VERT_MAX) vcnt_in = vcnt_ff + 1'b1;
         prev_u_in = cur_u_ff; prev_v_in = cur_v_ff; prev_r_in = cur_r_ff;
      end

      // table lookup
      if (cmd.tab_apply && !skip) begin
         case (code)
            EC_CROSS: parity_in = ~parity_ff;
            EC_BOUND: begin
               loop_fin_in  = 1'b1;
               edge_mark_in = vcnt_ff;
               loop_mark_in = lcnt_ff;
            end
            default: ;
         endcase
      end

      // exact compare products
      if (cmd.mul_p)  p_in = prod;
      if (cmd.mul_q1) q_in = prod;
      if (cmd.cmp1) begin
         c1pos_in = d_neg ? p_lt_q : p_gt_q;
         q_in     = prod;
      end
      if (cmd.cmp_apply) begin
         if (c1pos_ff) begin
            parity_in = ~parity_ff;
         end else if (!(d_neg ? p_gt_q : p_lt_q)) begin
            loop_fin_in  = 1'b1;
            edge_mark_in = vcnt_ff;
            loop_mark_in = lcnt_ff;
         end
      end

      // loop close: outer loop sets the verdict, holes can only cut it
      if (cmd.end_loop) begin
         if (!face_fin_ff) begin
            if (!outer_done_ff) begin
               verdict_in = loop_res;
               if (loop_res != RES_BOUNDARY) begin
                  edge_mark_in = '0;
                  loop_mark_in = '0;
               end
               if (loop_res == RES_OUTSIDE) face_fin_in = 1'b1;
            end else if (loop_res == RES_INSIDE) begin
               verdict_in   = RES_OUTSIDE;
               edge_mark_in = '0;
               loop_mark_in = lcnt_ff;
               face_fin_in  = 1'b1;
            end else if (loop_res == RES_BOUNDARY) begin
               verdict_in  = RES_BOUNDARY;
               face_fin_in = 1'b1;
            end
         end
         outer_done_in = 1'b1;
         if (lcnt_ff != LOOP_MAX) lcnt_in = lcnt_ff + 1'b1;
      end

      // deliver the face result and clear progress
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = verdict_ff;
         rsp_loop_in  = loop_mark_ff;
         rsp_edge_in  = (verdict_ff == RES_BOUNDARY) ? edge_mark_ff : '0;
         parity_in = 1'b0; loop_fin_in = 1'b0; face_fin_in = 1'b0;
         verdict_in = RES_OUTSIDE; vcnt_in = '0; lcnt_in = '0;
         edge_mark_in = '0; loop_mark_in = '0; outer_done_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff        <= TOL_RESET;
         axis_ff       <= AXIS_X;
         qu_ff         <= '0;
         qv_ff         <= '0;
         parity_ff     <= 1'b0;
         loop_fin_ff   <= 1'b0;
         face_fin_ff   <= 1'b0;
         outer_done_ff <= 1'b0;
         verdict_ff    <= RES_OUTSIDE;
         vcnt_ff       <= '0;
         lcnt_ff       <= '0;
         edge_mark_ff  <= '0;
         loop_mark_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) tol_ff <= csr_wdata;
         axis_ff       <= axis_in;
         qu_ff         <= qu_in;
         qv_ff         <= qv_in;
         parity_ff     <= parity_in;
         loop_fin_ff   <= loop_fin_in;
         face_fin_ff   <= face_fin_in;
         outer_done_ff <= outer_done_in;
         verdict_ff    <= verdict_in;
         vcnt_ff       <= vcnt_in;
         lcnt_ff       <= lcnt_in;
         edge_mark_ff  <= edge_mark_in;
         loop_mark_ff  <= loop_mark_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_u_ff   <= cur_u_in;   cur_v_ff   <= cur_v_in;   cur_r_ff   <= cur_r_in;
      prev_u_ff  <= prev_u_in;  prev_v_ff  <= prev_v_in;  prev_r_ff  <= prev_r_in;
      first_u_ff <= first_u_in; first_v_ff <= first_v_in; first_r_ff <= first_r_in;
      first_ff   <= first_in;   close_ff   <= close_in;   lface_ff   <= lface_in;
      p_ff       <= p_in;       q_ff       <= q_in;       c1pos_ff   <= c1pos_in;
      rsp_code_ff <= rsp_code_in;
      rsp_loop_ff <= rsp_loop_in;
      rsp_edge_ff <= rsp_edge_in;
   end

   // status and outputs
   always_comb begin
      stat.first        = first_ff;
      stat.closing      = close_ff;
      stat.last_face    = lface_ff;
      stat.exact_needed = (code == EC_EXACT) && !skip;
      stat.rsp_free     = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_code  = rsp_code_ff;
   assign rsp_decided_loop = rsp_loop_ff;
   assign rsp_decided_edge = rsp_edge_ff;

endmodule

`default_nettype wire

/* rtl/point_in_face_crossing_test_unit.sv */
// Point-in-face crossing test, top level: controller plus datapath.
// Depends on pifct_pkg, pifct_ctrl and pifct_datapath.
//
// Usage: send a query word (req_op = 0) with the point and the face normal,
// then one vertex word (req_op = 1) per loop vertex, outer loop first, with
// first_of_loop / last_of_loop / last_of_face marks. The word with
// last_of_face yields one result word on rsp_: outside, inside or boundary,
// with the loop and edge that decided it.
// Steps: a query word is taken in as it is accepted. A vertex word is accepted
// and then opened, then each edge gets a table lookup, plus the exact
// intersection compare when it is needed, which runs its three products
// through one shared 34x34 multiplier, and a step past an ordinary edge;
// a closing vertex handles its ordinary edge, if any, the closing edge and a
// loop close, and the last one adds a step to load the result register.
// req_stall is high while a vertex word is being worked on.
// If rsp_stall holds the result, the next face's words are still taken up to
// its last vertex, which waits until the result register frees.
// Reset (synchronous, active high) sets the tolerance to 16, clears the
// query and face progress and empties the result register.
// csr_we writes boundary_tolerance; write it only while idle.
`default_nettype none

module point_in_face_crossing_test_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_op,
   input  wire logic signed [pifct_pkg::COORD_W-1:0] req_coord_x,
   input  wire logic signed [pifct_pkg::COORD_W-1:0] req_coord_y,
   input  wire logic signed [pifct_pkg::COORD_W-1:0] req_coord_z,
   input  wire logic signed [pifct_pkg::COORD_W-1:0] req_normal_x,
   input  wire logic signed [pifct_pkg::COORD_W-1:0] req_normal_y,
   input  wire logic signed [pifct_pkg::COORD_W-1:0] req_normal_z,
   input  wire logic                            req_first_of_loop,
   input  wire logic                            req_last_of_loop,
   input  wire logic                            req_last_of_face,
   input  wire logic                            csr_we,
   input  wire logic [pifct_pkg::TOL_W-1:0]     csr_wdata,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [pifct_pkg::RES_W-1:0]          rsp_result_code,
   output logic [pifct_pkg::LOOP_W-1:0]         rsp_decided_loop,
   output logic [pifct_pkg::VERT_W-1:0]         rsp_decided_edge
);
   import pifct_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pifct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pifct_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_op),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_coord_z       (req_coord_z),
      .req_normal_x      (req_normal_x),
      .req_normal_y      (req_normal_y),
      .req_normal_z      (req_normal_z),
      .req_first_of_loop (req_first_of_loop),
      .req_last_of_loop  (req_last_of_loop),
      .req_last_of_face  (req_last_of_face),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_code   (rsp_result_code),
      .rsp_decided_loop  (rsp_decided_loop),
      .rsp_decided_edge  (rsp_decided_edge)
   );

   // a result is loaded only into a free result register
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || !rsp_stall))
      else $error("result loaded over a held result");

   // an accepted vertex word holds off the next word: req_stall is high in the cycle after it
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_op) |=> req_stall)
      else $error("vertex word not held off");

   // only a boundary result carries an edge index
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_code != RES_BOUNDARY) |-> (rsp_decided_edge == '0))
      else $error("edge index on a non-boundary result");

   // the result code is never the unused code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_code == RES_OUTSIDE || rsp_result_code == RES_INSIDE
                     || rsp_result_code == RES_BOUNDARY))
      else $error("bad result code");

endmodule

`default_nettype wire

/* tb/sv/point_in_face_crossing_test_unit_tb.sv */
// Testbench for point_in_face_crossing_test_unit: streams query and vertex words,
// predicts each face verdict in fixed point and checks every result word.
// Depends on pifct_pkg and the point_in_face_crossing_test_unit RTL.
`default_nettype none

module point_in_face_crossing_test_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pifct_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_WORDS = 1450;
   localparam int VERT_SAT = 1023;
   localparam int LOOP_SAT = 15;
   localparam bit OP_QUERY = 1'b0;
   localparam bit OP_VERTEX = 1'b1;

   // own copy of the crossing table, row is end region, column is start region
   localparam edge_code_type XTAB [0:8][0:8] = '{
      '{EC_NONE, EC_NONE, EC_CROSS, EC_NONE, EC_BOUND, EC_CROSS, EC_NONE, EC_NONE, EC_EXACT},
      '{EC_NONE, EC_NONE, EC_CROSS, EC_NONE, EC_BOUND, EC_CROSS, EC_NONE, EC_BOUND, EC_CROSS},
      '{EC_CROSS, EC_CROSS, EC_NONE, EC_CROSS, EC_BOUND, EC_NONE, EC_EXACT, EC_NONE, EC_NONE},
      '{EC_NONE, EC_NONE, EC_CROSS, EC_NONE, EC_BOUND, EC_BOUND, EC_NONE, EC_NONE, EC_NONE},
      '{EC_BOUND, EC_BOUND, EC_BOUND, EC_BOUND, EC_BOUND, EC_BOUND, EC_BOUND, EC_BOUND,
        EC_BOUND},
      '{EC_CROSS, EC_CROSS, EC_NONE, EC_BOUND, EC_BOUND, EC_NONE, EC_NONE, EC_NONE, EC_NONE},
      '{EC_NONE, EC_NONE, EC_EXACT, EC_NONE, EC_BOUND, EC_NONE, EC_NONE, EC_NONE, EC_NONE},
      '{EC_NONE, EC_BOUND, EC_NONE, EC_NONE, EC_BOUND, EC_NONE, EC_NONE, EC_NONE, EC_NONE},
      '{EC_EXACT, EC_CROSS, EC_NONE, EC_NONE, EC_BOUND, EC_NONE, EC_NONE, EC_NONE, EC_NONE}
   };

   typedef struct {
      bit op;
      logic signed [COORD_W-1:0] cx, cy, cz, nx, ny, nz;
      bit first, last_loop, last_face;
   } word_type;

   typedef struct {
      res_type code;
      logic [LOOP_W-1:0] dloop;
      logic [VERT_W-1:0] dedge;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = 1'b0;
   logic signed [COORD_W-1:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic signed [COORD_W-1:0] req_normal_x = '0, req_normal_y = '0, req_normal_z = '0;
   logic req_first_of_loop = 1'b0, req_last_of_loop = 1'b0, req_last_of_face = 1'b0;
   logic csr_we = 1'b0;
   logic [TOL_W-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [RES_W-1:0] rsp_result_code;
   logic [LOOP_W-1:0] rsp_decided_loop;
   logic [VERT_W-1:0] rsp_decided_edge;

   point_in_face_crossing_test_unit dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predicted face state
   longint tol, qu, qv, pu, pv, fu, fv;
   int axis, pr, fr, verdict, vcnt, lcnt, emark, lmark;
   bit parity, loop_fin, face_fin, outer_done;

   verdict_type verdict_q[$];
   int fails = 0;
   int words_sent = 0;
   int cycles = 0;
   int snd_idle_pct = 0;
   int rcv_stall_pct = 0;

   function automatic longint abs64(longint a);
      return a < 0 ? -a : a;
   endfunction

   function automatic int region_of(longint u, longint v);
      int r;
      r = (u > qu + tol) ? 0 : ((u < qu - tol) ? 6 : 3);
      r += (v > qv + tol) ? 0 : ((v < qv - tol) ? 2 : 1);
      return r;
   endfunction

   function automatic void hit_boundary(int idx);
      loop_fin = 1;
      if (!face_fin) begin
         emark = idx;
         lmark = lcnt;
      end
   endfunction

   // one edge of the loop, idx is its start vertex index
   function automatic void walk_edge(longint u0, longint v0, int r0,
                                     longint u1, longint v1, int r1, int idx);
      edge_code_type code;
      logic signed [127:0] p, a1, a2, du, dv, d, e1, e2;
      int c1, c2;
      if (loop_fin || face_fin) return;
      code = XTAB[r1][r0];
      if (code == EC_CROSS) begin
         parity ^= 1;
      end else if (code == EC_BOUND) begin
         hit_boundary(idx);
      end else if (code == EC_EXACT) begin
         d = v0 - v1;
         du = u0 - u1;
         dv = qv - v1;
         e1 = qu + tol - u1;
         e2 = qu - tol - u1;
         p = du * dv;
         a1 = e1 * d;
         a2 = e2 * d;
         c1 = (p > a1) ? 1 : ((p < a1) ? -1 : 0);
         c2 = (p > a2) ? 1 : ((p < a2) ? -1 : 0);
         if (d < 0) begin
            c1 = -c1;
            c2 = -c2;
         end
         if (c1 > 0) parity ^= 1;
         else if (c2 < 0) ;
         else hit_boundary(idx);
      end
   endfunction

   function automatic void close_loop();
      int lr;
      lr = loop_fin ? 2 : (parity ? 1 : 0);
      if (!face_fin) begin
         if (!outer_done) begin
            verdict = lr;
            if (lr != 2) begin
               emark = 0;
               lmark = 0;
            end
            if (lr == 0) face_fin = 1;
         end else if (lr == 1) begin
            verdict = 0;
            emark = 0;
            lmark = lcnt;
            face_fin = 1;
         end else if (lr == 2) begin
            verdict = 2;
            face_fin = 1;
         end
      end
      outer_done = 1;
      if (lcnt < LOOP_SAT) lcnt++;
   endfunction

   function automatic void clear_face();
      parity = 0; loop_fin = 0; face_fin = 0; verdict = 0;
      vcnt = 0; lcnt = 0; emark = 0; lmark = 0; outer_done = 0;
   endfunction

   // advance the face state by one accepted word, queue a verdict on face end
   function automatic void predict_word(word_type w);
      longint c[3], n[3], u, v;
      int r;
      verdict_type x;
      c[0] = w.cx; c[1] = w.cy; c[2] = w.cz;
      if (w.op == OP_QUERY) begin
         n[0] = abs64(longint'(w.nx));
         n[1] = abs64(longint'(w.ny));
         n[2] = abs64(longint'(w.nz));
         if (n[0] >= n[1] && n[0] >= n[2]) axis = 0;
         else if (n[1] >= n[2]) axis = 1;
         else axis = 2;
         qu = c[axis == 0 ? 1 : 0];
         qv = c[axis == 2 ? 1 : 2];
         clear_face();
         return;
      end
      u = c[axis == 0 ? 1 : 0];
      v = c[axis == 2 ? 1 : 2];
      r = region_of(u, v);
      if (w.first) begin
         vcnt = 0; parity = 0; loop_fin = 0;
         fu = u; fv = v; fr = r;
      end else begin
         walk_edge(pu, pv, pr, u, v, r, vcnt);
         if (vcnt < VERT_SAT) vcnt++;
      end
      pu = u; pv = v; pr = r;
      if (w.last_loop || w.last_face) begin
         walk_edge(u, v, r, fu, fv, fr, vcnt);
         close_loop();
      end
      if (w.last_face) begin
         x.code = res_type'(verdict[1:0]);
         x.dloop = lmark[LOOP_W-1:0];
         x.dedge = (verdict == 2) ? emark[VERT_W-1:0] : '0;
         verdict_q.push_back(x);
         clear_face();
      end
   endfunction

   // drive one word, wait for its acceptance, then predict
   task automatic send_word(word_type w);
      while ($urandom_range(99) < snd_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_op <= w.op;
      req_coord_x <= w.cx; req_coord_y <= w.cy; req_coord_z <= w.cz;
      req_normal_x <= w.nx; req_normal_y <= w.ny; req_normal_z <= w.nz;
      req_first_of_loop <= w.first;
      req_last_of_loop <= w.last_loop;
      req_last_of_face <= w.last_face;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      predict_word(w);
      words_sent++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic void place_uv(longint u, longint v, longint d, int ax,
                                    inout word_type w);
      case (ax)
         0: begin w.cx = COORD_W'(d); w.cy = COORD_W'(u); w.cz = COORD_W'(v); end
         1: begin w.cx = COORD_W'(u); w.cy = COORD_W'(d); w.cz = COORD_W'(v); end
         default: begin w.cx = COORD_W'(u); w.cy = COORD_W'(v); w.cz = COORD_W'(d); end
      endcase
   endfunction

   // query with a normal whose dominant axis is ax; dropped is the dropped coordinate
   task automatic send_query(longint u, longint v, int ax);
      word_type w;
      longint big, s1, s2, dropped;
      big = $urandom_range(32'h7fff_ffff, 32'h0001_0000);
      s1 = $urandom_range(32'h0000_ffff);
      s2 = $urandom_range(32'h0000_ffff);
      dropped = $signed($urandom);
      w = '{default: '0};
      w.op = OP_QUERY;
      place_uv(u, v, dropped, ax, w);
      if ($urandom_range(1)) big = -big;
      w.nx = COORD_W'((ax == 0) ? big : s1);
      w.ny = COORD_W'((ax == 1) ? big : ((ax == 0) ? s1 : s2));
      w.nz = COORD_W'((ax == 2) ? big : s2);
      if ($urandom_range(1)) w.ny = -w.ny;
      if ($urandom_range(1)) w.nz = -w.nz;
      send_word(w);
   endtask

   function automatic word_type vertex_at(longint u, longint v, bit f, bit l, bit lf);
      word_type w;
      w = '{default: '0};
      w.op = OP_VERTEX;
      w.nx = $urandom; w.ny = $urandom; w.nz = $urandom;
      place_uv(u, v, longint'($signed($urandom)), axis, w);
      w.first = f; w.last_loop = l; w.last_face = lf;
      return w;
   endfunction

   // offset at the tolerance box edges or centre, in a band around the box, or well away from it
   function automatic longint pick_offset();
      case ($urandom_range(7))
         0: return -tol - 1;
         1: return -tol;
         2: return 0;
         3: return tol;
         4: return tol + 1;
         5: return longint'($urandom_range(6 * tol + 8)) - (3 * tol + 4);
         default: return longint'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
      endcase
   endfunction

   // one loop: a square of half size s around (cu, cv), or n scattered vertices
   task automatic send_loop(int n, bit square, longint cu, longint cv, longint s,
                            bit end_face);
      longint su[4], sv[4];
      bit l;
      su = '{cu + s, cu - s, cu - s, cu + s};
      sv = '{cv + s, cv + s, cv - s, cv - s};
      if (square) n = 4;
      for (int i = 0; i < n; i++) begin
         l = (i == n - 1);
         if (square) send_word(vertex_at(su[i], sv[i], i == 0,
                                         l && !(end_face && $urandom_range(1) == 0),
                                         l && end_face));
         else send_word(vertex_at(qu + pick_offset(), qv + pick_offset(), i == 0,
                                  l && !(end_face && $urandom_range(1) == 0),
                                  l && end_face));
      end
   endtask

   task automatic write_tolerance(longint t);
      wait (verdict_q.size() == 0);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= t[TOL_W-1:0];
      @(posedge clock);
      tol = t;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // result word checker
   always @(posedge clock) begin
      verdict_type x;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $error("result word with no verdict pending");
            fails++;
         end else begin
            x = verdict_q.pop_front();
            if (rsp_result_code !== x.code) begin
               $error("result_code expected %0d got %0d", x.code, rsp_result_code);
               fails++;
            end
            if (rsp_decided_loop !== x.dloop) begin
               $error("decided_loop expected %0d got %0d", x.dloop, rsp_decided_loop);
               fails++;
            end
            if (rsp_decided_edge !== x.dedge) begin
               $error("decided_edge expected %0d got %0d", x.dedge, rsp_decided_edge);
               fails++;
            end
         end
      end
   end

   // receiver stall
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < rcv_stall_pct);

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic test_directed();
      word_type w;
      // square around the point: inside; square off to the side: outside
      send_query(0, 0, 2);
      send_loop(4, 1, 0, 0, 1000, 1);
      send_query(0, 0, 0);
      send_loop(4, 1, 5000, 5000, 1000, 1);
      // point on the outer edge
      send_query(1000, 0, 1);
      send_loop(4, 1, 0, 0, 1000, 1);
      // hole around the point, then point on a hole edge
      send_query(0, 0, 2);
      send_loop(4, 1, 0, 0, 4000, 0);
      send_loop(4, 1, 0, 0, 500, 1);
      send_query(500, 10, 2);
      send_loop(4, 1, 0, 0, 4000, 0);
      send_loop(4, 1, 0, 0, 500, 1);
      // diagonal edge through the box needs the exact compare
      send_query(0, 0, 2);
      send_word(vertex_at(100, 100, 1, 0, 0));
      send_word(vertex_at(-100, -100, 0, 0, 0));
      send_word(vertex_at(-100, 300, 0, 1, 1));
      // normal ties: all equal drops x, y and z equal drops y
      w = '{default: '0};
      w.op = OP_QUERY;
      w.nx = 32'h8000_0000; w.ny = 32'h8000_0000; w.nz = 32'h8000_0000;
      send_word(w);
      w.nx = 1; w.ny = -7; w.nz = 7;
      send_word(w);
      // extreme coordinates on every field
      w = '{default: '0};
      w.op = OP_VERTEX; w.first = 1;
      w.cx = 32'h7fff_ffff; w.cy = 32'h8000_0000; w.cz = 32'h7fff_ffff;
      w.nx = 32'h7fff_ffff; w.ny = 32'h8000_0000; w.nz = 32'hffff_ffff;
      send_word(w);
      w.first = 0; w.cx = 32'h8000_0000; w.cy = 32'h7fff_ffff; w.cz = 32'h8000_0000;
      send_word(w);
      w.cy = 32'h8000_0000; w.last_face = 1;
      send_word(w);
   endtask

   task automatic test_saturation();
      send_query(0, 0, 2);
      for (int i = 0; i < 17; i++) send_loop(3, 0, 0, 0, 0, i == 16);
      send_query(0, 0, 1);
      send_loop(1030, 0, 0, 0, 0, 1);
   endtask

   // well-formed faces with random content, plus some fully random words
   task automatic test_random(int target);
      word_type w;
      int nl;
      longint s;
      while (words_sent < target) begin
         if ($urandom_range(9) == 0) begin
            w = '{default: '0};
            w.op = 1'($urandom_range(1));
            w.cx = $urandom; w.cy = $urandom; w.cz = $urandom;
            w.nx = $urandom; w.ny = $urandom; w.nz = $urandom;
            w.first = 1;
            w.last_loop = 1'($urandom_range(1)); w.last_face = 1'($urandom_range(1));
            send_word(w);
            w.op = OP_VERTEX; w.first = 1'($urandom_range(1));
            w.cx = $urandom; w.cy = $urandom; w.cz = $urandom;
            w.last_loop = 1'($urandom_range(1)); w.last_face = 1;
            send_word(w);
         end else begin
            if ($urandom_range(9) != 0)
               send_query(longint'($urandom_range(32'h0200_0000)) - 32'h0100_0000,
                          longint'($urandom_range(32'h0200_0000)) - 32'h0100_0000,
                          $urandom_range(2));
            nl = $urandom_range(1, 4);
            for (int i = 0; i < nl; i++) begin
               s = tol + 1 + $urandom_range(4000);
               if ($urandom_range(9) < 6)
                  send_loop(4, 1, qu + pick_offset() / 4, qv + pick_offset() / 4,
                            s >> (i == 0 ? 0 : 1), i == nl - 1);
               else
                  send_loop($urandom_range(3, 8), 0, 0, 0, 0, i == nl - 1);
            end
         end
      end
   endtask

   initial begin
      tol = TOL_RESET;
      qu = 0; qv = 0; axis = 0; pu = 0; pv = 0; fu = 0; fv = 0; pr = 0; fr = 0;
      clear_face();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      write_tolerance(0);
      test_directed();
      test_saturation();

      // random phases fill the rest of the word budget
      write_tolerance(65535);
      snd_idle_pct = 50;
      test_random(words_sent + 70);
      write_tolerance(16);
      snd_idle_pct = 0; rcv_stall_pct = 50;
      test_random(words_sent + 70);
      write_tolerance($urandom_range(65535));
      snd_idle_pct = 17; rcv_stall_pct = 17;
      test_random(words_sent + 70);
      write_tolerance(0);
      snd_idle_pct = 0; rcv_stall_pct = 0;
      test_random((words_sent + 70 > RANDOM_WORDS) ? words_sent + 70 : RANDOM_WORDS);

      wait (verdict_q.size() == 0);
      repeat (30) @(posedge clock);
      if (fails == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
